// ----- hdl/see_pkg.sv -----
// shared types and constants of the symmetric epipolar error scorer
`default_nettype none
package see_pkg;

    // coefficient width of one entry of F (Q0.(COEF_BITS-1))
    localparam int COEF_BITS = 21;
    localparam int COORD_W   = 16;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 2;

    // exact widths of the intermediate results
    localparam int LINE_W  = COEF_BITS + COORD_W + 3;
    localparam int RES_W   = LINE_W + COORD_W + 2;
    localparam int MAC_A_W = RES_W + 1;
    localparam int MAC_B_W = COORD_W + 1;
    localparam int PROD_W  = MAC_A_W + MAC_B_W;
    localparam int CHUNK_W = 16;
    localparam int MAG_W   = 64;
    localparam int ACC_W   = 128;
    localparam int DEN_W   = 2 * LINE_W;
    localparam int NUM_W   = 2 * RES_W;
    localparam int Q_W     = 48;
    localparam int DIV_W   = DEN_W + Q_W;
    localparam int SUM_W   = 63;
    localparam int CNT_W   = 6;

    localparam int R_CHUNKS = (RES_W + CHUNK_W - 1) / CHUNK_W;
    localparam int L_CHUNKS = (LINE_W + CHUNK_W - 1) / CHUNK_W;

    localparam logic [Q_W-1:0]   MAX_TERM = '1;
    localparam logic [SUM_W-1:0] MAX_SUM  = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_F_ROW0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_F_ROW1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_F_ROW2 = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LINE1,
        ST_LINE0,
        ST_RESID,
        ST_SQR,
        ST_DEN0,
        ST_DEN1,
        ST_DINIT,
        ST_DSTEP,
        ST_DSTORE,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        ASEL_COEF,
        ASEL_LINE1,
        ASEL_MAG0,
        ASEL_MAG1,
        ASEL_MAGR
    } asel_t;

    typedef enum logic [2:0] {
        BSEL_X0,
        BSEL_Y0,
        BSEL_X1,
        BSEL_Y1,
        BSEL_SIXTEEN,
        BSEL_CHUNK
    } bsel_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_L1,
        DST_L0,
        DST_R,
        DST_R2,
        DST_DEN0,
        DST_DEN1
    } dst_t;

    typedef struct packed {
        logic       load;
        logic       mac;
        logic       acc_clr;
        asel_t      asel;
        bsel_t      bsel;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] idx;
        logic [1:0] chunk;
        dst_t       dst;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic       div_sel;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ----- hdl/see_ctrl.sv -----
// sequencer that steps the datapath through one correspondence
`default_nettype none
module see_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire see_pkg::status_t status,
    output see_pkg::cmd_t        cmd
);
    import see_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]         idx_reg, idx_next;
    logic               div_sel_reg, div_sel_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            div_sel_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            div_sel_reg <= div_sel_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        div_sel_next = div_sel_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LINE1;
                    cnt_next   = '0;
                    idx_next   = '0;
                end
            end
            ST_LINE1, ST_LINE0: begin
                cmd.mac     = 1'b1;
                cmd.acc_clr = (cnt_reg == '0);
                cmd.asel    = ASEL_COEF;
                cmd.idx     = idx_reg;
                if (state_reg == ST_LINE1) begin
                    cmd.row = idx_reg;
                    cmd.col = cnt_reg[1:0];
                end else begin
                    cmd.row = cnt_reg[1:0];
                    cmd.col = idx_reg;
                end
                case (cnt_reg[1:0])
                    2'd0:    cmd.bsel = (state_reg == ST_LINE1) ? BSEL_X0 : BSEL_X1;
                    2'd1:    cmd.bsel = (state_reg == ST_LINE1) ? BSEL_Y0 : BSEL_Y1;
                    default: cmd.bsel = BSEL_SIXTEEN;
                endcase
                if (cnt_reg == CNT_W'(2)) begin
                    cmd.dst  = (state_reg == ST_LINE1) ? DST_L1 : DST_L0;
                    cnt_next = '0;
                    if (idx_reg == 2'd2) begin
                        idx_next   = '0;
                        state_next = (state_reg == ST_LINE1) ? ST_LINE0 : ST_RESID;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_RESID: begin
                cmd.mac     = 1'b1;
                cmd.acc_clr = (cnt_reg == '0);
                cmd.asel    = ASEL_LINE1;
                cmd.idx     = cnt_reg[1:0];
                case (cnt_reg[1:0])
                    2'd0:    cmd.bsel = BSEL_X1;
                    2'd1:    cmd.bsel = BSEL_Y1;
                    default: cmd.bsel = BSEL_SIXTEEN;
                endcase
                if (cnt_reg == CNT_W'(2)) begin
                    cmd.dst    = DST_R;
                    cnt_next   = '0;
                    state_next = ST_SQR;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SQR: begin
                cmd.mac     = 1'b1;
                cmd.acc_clr = (cnt_reg == '0);
                cmd.asel    = ASEL_MAGR;
                cmd.bsel    = BSEL_CHUNK;
                cmd.chunk   = cnt_reg[1:0];
                if (cnt_reg == CNT_W'(R_CHUNKS - 1)) begin
                    cmd.dst    = DST_R2;
                    cnt_next   = '0;
                    idx_next   = '0;
                    state_next = ST_DEN0;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DEN0, ST_DEN1: begin
                cmd.mac     = 1'b1;
                cmd.acc_clr = (cnt_reg == '0) && (idx_reg == '0);
                cmd.asel    = (state_reg == ST_DEN0) ? ASEL_MAG0 : ASEL_MAG1;
                cmd.bsel    = BSEL_CHUNK;
                cmd.idx     = idx_reg;
                cmd.chunk   = cnt_reg[1:0];
                if (cnt_reg == CNT_W'(L_CHUNKS - 1)) begin
                    cnt_next = '0;
                    if (idx_reg == 2'd1) begin
                        idx_next = '0;
                        if (state_reg == ST_DEN0) begin
                            cmd.dst    = DST_DEN0;
                            state_next = ST_DEN1;
                        end else begin
                            cmd.dst      = DST_DEN1;
                            div_sel_next = 1'b0;
                            state_next   = ST_DINIT;
                        end
                    end else begin
                        idx_next = 2'd1;
                    end
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                cmd.div_sel  = div_sel_reg;
                cnt_next     = '0;
                state_next   = ST_DSTEP;
            end
            ST_DSTEP: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(Q_W - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DSTORE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DSTORE: begin
                cmd.div_store = 1'b1;
                cmd.div_sel   = div_sel_reg;
                if (!div_sel_reg) begin
                    div_sel_next = 1'b1;
                    state_next   = ST_DINIT;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/see_datapath.sv -----
// datapath: F registers, multiply-accumulate unit, divider and result register
`default_nettype none
module see_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    input  wire logic [see_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [see_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic signed [see_pkg::COORD_W-1:0] s_first_x,
    input  wire logic signed [see_pkg::COORD_W-1:0] s_first_y,
    input  wire logic signed [see_pkg::COORD_W-1:0] s_second_x,
    input  wire logic signed [see_pkg::COORD_W-1:0] s_second_y,
    input  wire logic                              s_last_point,
    input  wire see_pkg::cmd_t                     cmd,
    output see_pkg::status_t                       status,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [see_pkg::Q_W-1:0]                m_point_error,
    output logic [see_pkg::SUM_W-1:0]              m_running_total,
    output logic                                   m_degenerate,
    output logic                                   m_set_end
);
    import see_pkg::*;

    function automatic logic [MAG_W-1:0] mag_line(input logic signed [LINE_W-1:0] v);
        logic [LINE_W-1:0] m;
        begin
            m = v[LINE_W-1] ? LINE_W'(-v) : LINE_W'(v);
            return MAG_W'(m);
        end
    endfunction

    function automatic logic [MAG_W-1:0] mag_res(input logic signed [RES_W-1:0] v);
        logic [RES_W-1:0] m;
        begin
            m = v[RES_W-1] ? RES_W'(-v) : RES_W'(v);
            return MAG_W'(m);
        end
    endfunction

    logic [CFG_W-1:0]           f_row0_reg, f_row1_reg, f_row2_reg;
    logic signed [COORD_W-1:0]  x0_reg, y0_reg, x1_reg, y1_reg;
    logic                       last_reg;
    logic signed [LINE_W-1:0]   l1_reg [3];
    logic signed [LINE_W-1:0]   l0_reg [3];
    logic signed [RES_W-1:0]    r_reg;
    logic [NUM_W-1:0]           r2_reg;
    logic [DEN_W-1:0]           den0_reg, den1_reg;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [DIV_W-1:0]           rem_reg, dsh_reg;
    logic [Q_W-1:0]             q_reg, d0_reg, d1_reg;
    logic                       tsat_reg, flag0_reg, flag1_reg;
    logic [SUM_W-1:0]           err_reg;
    logic                       m_valid_reg;
    logic [Q_W-1:0]             m_point_error_reg;
    logic [SUM_W-1:0]           m_running_total_reg;
    logic                       m_degenerate_reg, m_set_end_reg;

    logic [CFG_W-1:0]           row_val;
    logic [COEF_BITS-1:0]       coef_field;
    logic [MAG_W-1:0]           mag_src;
    logic signed [MAC_A_W-1:0]  a_val;
    logic signed [MAC_B_W-1:0]  b_val;
    logic signed [PROD_W-1:0]   prod;
    logic [CNT_W-1:0]           shamt;
    logic [ACC_W-1:0]           shifted;
    logic [DEN_W-1:0]           den_sel;
    logic                       rem_ge;
    logic [Q_W:0]               d_sum;
    logic [Q_W-1:0]             d_val;
    logic [SUM_W:0]             total_sum;
    logic [SUM_W-1:0]           total_val;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_row0_reg <= '0;
            f_row1_reg <= '0;
            f_row2_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_F_ROW0: f_row0_reg <= cfg_data;
                REG_F_ROW1: f_row1_reg <= cfg_data;
                REG_F_ROW2: f_row2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // coefficient selection
    always_comb begin
        case (cmd.row)
            2'd0:    row_val = f_row0_reg;
            2'd1:    row_val = f_row1_reg;
            2'd2:    row_val = f_row2_reg;
            default: row_val = '0;
        endcase
        case (cmd.col)
            2'd0:    coef_field = row_val[0 +: COEF_BITS];
            2'd1:    coef_field = row_val[COEF_BITS +: COEF_BITS];
            2'd2:    coef_field = row_val[2*COEF_BITS +: COEF_BITS];
            default: coef_field = '0;
        endcase
    end

    // multiplier operands
    always_comb begin
        case (cmd.asel)
            ASEL_MAG0: mag_src = mag_line(l0_reg[cmd.idx]);
            ASEL_MAG1: mag_src = mag_line(l1_reg[cmd.idx]);
            ASEL_MAGR: mag_src = mag_res(r_reg);
            default:   mag_src = '0;
        endcase
        case (cmd.asel)
            ASEL_COEF:  a_val = MAC_A_W'($signed(coef_field));
            ASEL_LINE1: a_val = MAC_A_W'(l1_reg[cmd.idx]);
            default:    a_val = $signed({1'b0, mag_src[MAC_A_W-2:0]});
        endcase
        case (cmd.bsel)
            BSEL_X0:      b_val = MAC_B_W'(x0_reg);
            BSEL_Y0:      b_val = MAC_B_W'(y0_reg);
            BSEL_X1:      b_val = MAC_B_W'(x1_reg);
            BSEL_Y1:      b_val = MAC_B_W'(y1_reg);
            BSEL_SIXTEEN: b_val = MAC_B_W'(16);
            default:      b_val = $signed({1'b0, mag_src[cmd.chunk*CHUNK_W +: CHUNK_W]});
        endcase
        shamt = (cmd.bsel == BSEL_CHUNK) ? {cmd.chunk, 4'b0000} : '0;
    end

    // multiply-accumulate
    assign prod     = a_val * b_val;
    assign shifted  = ACC_W'(prod) << shamt;
    assign acc_next = (cmd.acc_clr ? '0 : acc_reg) + shifted;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x0_reg   <= s_first_x;
            y0_reg   <= s_first_y;
            x1_reg   <= s_second_x;
            y1_reg   <= s_second_y;
            last_reg <= s_last_point;
        end
        if (cmd.mac) begin
            acc_reg <= acc_next;
            case (cmd.dst)
                DST_L1:   l1_reg[cmd.idx] <= acc_next[LINE_W-1:0];
                DST_L0:   l0_reg[cmd.idx] <= acc_next[LINE_W-1:0];
                DST_R:    r_reg           <= acc_next[RES_W-1:0];
                DST_R2:   r2_reg          <= acc_next[NUM_W-1:0];
                DST_DEN0: den0_reg        <= acc_next[DEN_W-1:0];
                DST_DEN1: den1_reg        <= acc_next[DEN_W-1:0];
                default: ;
            endcase
        end
    end

    // restoring divider, one quotient bit per cycle
    assign den_sel = cmd.div_sel ? den1_reg : den0_reg;
    assign rem_ge  = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg  <= DIV_W'(r2_reg);
            dsh_reg  <= DIV_W'(den_sel) << (Q_W - 1);
            q_reg    <= '0;
            tsat_reg <= (den_sel == '0) || (DIV_W'(r2_reg) >= (DIV_W'(den_sel) << Q_W));
        end else if (cmd.div_step) begin
            if (rem_ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[Q_W-2:0], rem_ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.div_store) begin
            if (cmd.div_sel) begin
                d1_reg    <= tsat_reg ? MAX_TERM : q_reg;
                flag1_reg <= tsat_reg;
            end else begin
                d0_reg    <= tsat_reg ? MAX_TERM : q_reg;
                flag0_reg <= tsat_reg;
            end
        end
    end

    // point error and running total with saturation
    assign d_sum     = {1'b0, d0_reg} + {1'b0, d1_reg};
    assign d_val     = d_sum[Q_W] ? MAX_TERM : d_sum[Q_W-1:0];
    assign total_sum = {1'b0, err_reg} + (SUM_W + 1)'(d_val);
    assign total_val = total_sum[SUM_W] ? MAX_SUM : total_sum[SUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            err_reg     <= last_reg ? '0 : total_val;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_point_error_reg   <= d_val;
            m_running_total_reg <= total_val;
            m_degenerate_reg    <= flag0_reg | flag1_reg | d_sum[Q_W] | total_sum[SUM_W];
            m_set_end_reg       <= last_reg;
        end
    end

    assign status.out_free  = !m_valid_reg || m_ready;
    assign m_valid          = m_valid_reg;
    assign m_point_error    = m_point_error_reg;
    assign m_running_total  = m_running_total_reg;
    assign m_degenerate     = m_degenerate_reg;
    assign m_set_end        = m_set_end_reg;

endmodule
`default_nettype wire

// ----- hdl/symmetric_epipolar_error.sv -----
// top level of the symmetric epipolar error scorer
// Scores one point correspondence per input transfer against the
// fundamental matrix F held in three configuration registers.
// Configuration: cfg_valid/cfg_ready with cfg_index (0..2 = F rows 0..2)
// and cfg_data; cfg_ready is always high, other indexes are ignored.
// Write F only while no point is in flight.
// Input: s_valid/s_ready with both points and last_point. Output:
// m_valid/m_ready with point_error, running_total, degenerate, set_end.
// One point is in work at a time: 37 multiply-accumulate steps on the
// single shared 59x17 multiplier, then two passes of the restoring
// divider at one quotient bit per cycle.
// A finished result sits in the output register; the next point is taken
// while it waits, and only the final write of a later result holds off
// until the receiver takes the earlier one.
// Reset clears F, the running sum and the output valid.
// The running sum is cleared after a result with set_end high.
`default_nettype none
module symmetric_epipolar_error (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [see_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [see_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [see_pkg::COORD_W-1:0] s_first_x,
    input  wire logic signed [see_pkg::COORD_W-1:0] s_first_y,
    input  wire logic signed [see_pkg::COORD_W-1:0] s_second_x,
    input  wire logic signed [see_pkg::COORD_W-1:0] s_second_y,
    input  wire logic                               s_last_point,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [see_pkg::Q_W-1:0]                 m_point_error,
    output logic [see_pkg::SUM_W-1:0]               m_running_total,
    output logic                                    m_degenerate,
    output logic                                    m_set_end
);
    import see_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    see_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic and storage
    see_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_first_x       (s_first_x),
        .s_first_y       (s_first_y),
        .s_second_x      (s_second_x),
        .s_second_y      (s_second_y),
        .s_last_point    (s_last_point),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_point_error   (m_point_error),
        .m_running_total (m_running_total),
        .m_degenerate    (m_degenerate),
        .m_set_end       (m_set_end)
    );

    // block is busy right after an input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a point is in work");

    // a new result only appears at the end of a point's work
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result raised without a point in work");

    // the final write never overruns a waiting result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_running_total))
        else $error("waiting result overwritten");

endmodule
`default_nettype wire

// ----- tb/sv/tb_symmetric_epipolar_error.sv -----
// self-checking testbench of the symmetric epipolar error scorer
`default_nettype none
module tb_symmetric_epipolar_error;
    import see_pkg::*;

    // index outside the register list, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 3000000;
    localparam logic [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

    typedef struct {
        logic signed [COORD_W-1:0] fx, fy, sx, sy;
        logic                      last;
    } point_t;

    typedef struct {
        logic [Q_W-1:0]   point_error;
        logic [SUM_W-1:0] running_total;
        logic             degenerate;
        logic             set_end;
    } score_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [COORD_W-1:0] s_first_x = '0, s_first_y = '0;
    logic signed [COORD_W-1:0] s_second_x = '0, s_second_y = '0;
    logic s_last_point = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [Q_W-1:0] m_point_error;
    logic [SUM_W-1:0] m_running_total;
    logic m_degenerate;
    logic m_set_end;

    // shadow of the F rows and the running sum
    logic [CFG_W-1:0] f_rows [3];
    logic [SUM_W-1:0] set_sum;

    point_t pending_points[$];
    score_t expected_scores[$];
    int mismatches = 0;
    int cycles = 0;
    bit no_idle = 0;
    int send_gap = 0;
    int recv_stall = 0;

    symmetric_epipolar_error DUT (.*);

    always #1 aclk = ~aclk;

    function automatic longint coef_at(int row, int col);
        logic signed [COEF_BITS-1:0] c;
        c = f_rows[row][col*COEF_BITS +: COEF_BITS];
        return longint'(c);
    endfunction

    function automatic logic [127:0] sq_mag(longint v);
        logic [127:0] m;
        m = (v < 0) ? 128'(-v) : 128'(v);
        return m * m;
    endfunction

    // floor of num/den limited to 48 bits, flags a zero den or saturation
    function automatic logic [Q_W-1:0] limited_quotient(logic [127:0] num, logic [127:0] den,
                                                        inout logic flag);
        logic [127:0] q;
        if (den == 0 || num >= (den << Q_W)) begin
            flag = 1'b1;
            return MAX_TERM;
        end
        q = num / den;
        return q[Q_W-1:0];
    endfunction

    // expected score of one correspondence, advances the running sum
    function automatic score_t score_point(point_t p);
        longint f [3][3];
        longint l1 [3], l0 [3];
        longint x0, y0, x1, y1, r;
        logic [127:0] r2;
        logic [Q_W:0] d;
        logic [SUM_W:0] total;
        logic flag;
        score_t s;
        x0 = longint'(p.fx);
        y0 = longint'(p.fy);
        x1 = longint'(p.sx);
        y1 = longint'(p.sy);
        flag = 1'b0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                f[i][j] = coef_at(i, j);
        for (int i = 0; i < 3; i++) begin
            l1[i] = f[i][0] * x0 + f[i][1] * y0 + f[i][2] * 16;
            l0[i] = f[0][i] * x1 + f[1][i] * y1 + f[2][i] * 16;
        end
        r = x1 * l1[0] + y1 * l1[1] + 16 * l1[2];
        r2 = sq_mag(r);
        d = limited_quotient(r2, sq_mag(l0[0]) + sq_mag(l0[1]), flag);
        d = d + limited_quotient(r2, sq_mag(l1[0]) + sq_mag(l1[1]), flag);
        if (d > MAX_TERM) begin
            d = MAX_TERM;
            flag = 1'b1;
        end
        total = set_sum + d;
        if (total > MAX_SUM) begin
            total = MAX_SUM;
            flag = 1'b1;
        end
        set_sum = p.last ? '0 : total[SUM_W-1:0];
        s.point_error = d[Q_W-1:0];
        s.running_total = total[SUM_W-1:0];
        s.degenerate = flag;
        s.set_end = p.last;
        return s;
    endfunction

    function automatic int draw_wait();
        if (no_idle) return 0;
        return $urandom_range(0, 8);
    endfunction

    // input driver: presents queued points, waits a drawn gap after each transfer
    always @(posedge aclk) begin
        point_t p;
        if (!aresetn) begin
            s_valid <= 1'b0;
            set_sum = '0;
        end else begin
            if (s_valid && s_ready) begin
                p.fx = s_first_x; p.fy = s_first_y;
                p.sx = s_second_x; p.sy = s_second_y;
                p.last = s_last_point;
                expected_scores = {expected_scores, score_point(p)};
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_points.size() > 0) begin
                    p = pending_points.pop_front();
                    s_first_x <= p.fx; s_first_y <= p.fy;
                    s_second_x <= p.sx; s_second_y <= p.sy;
                    s_last_point <= p.last;
                    s_valid <= 1'b1;
                    send_gap = draw_wait();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each transfer against the oldest expected score
    always @(posedge aclk) begin
        score_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_scores.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: err=%h total=%h deg=%b end=%b",
                                 m_point_error, m_running_total, m_degenerate, m_set_end);
                end else begin
                    e = expected_scores.pop_front();
                    if (m_point_error !== e.point_error || m_running_total !== e.running_total
                        || m_degenerate !== e.degenerate || m_set_end !== e.set_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: err exp %h got %h, total exp %h got %h, %s",
                                     e.point_error, m_point_error, e.running_total,
                                     m_running_total,
                                     $sformatf("deg exp %b got %b, end exp %b got %b",
                                               e.degenerate, m_degenerate,
                                               e.set_end, m_set_end));
                    end
                end
                recv_stall = draw_wait();
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx != REG_UNUSED) f_rows[idx] = data;
    endtask

    // sampled mid-cycle so the driver's updates of this edge are settled
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_points.size() > 0 || s_valid || expected_scores.size() > 0)
            @(negedge aclk);
    endtask

    task automatic add_point(int fx, int fy, int sx, int sy, bit last);
        point_t p;
        p.fx = fx[COORD_W-1:0]; p.fy = fy[COORD_W-1:0];
        p.sx = sx[COORD_W-1:0]; p.sy = sy[COORD_W-1:0];
        p.last = last;
        pending_points = {pending_points, p};
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            1, 2: return COORD_W'($signed($urandom_range(0, 2000)) - 1000);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] rand_coef();
        logic [COEF_BITS-1:0] c;
        case ($urandom_range(0, 6))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            default: begin
                c = COEF_BITS'($urandom);
                return COEF_BITS'($signed(c) >>> $urandom_range(0, COEF_BITS - 1));
            end
        endcase
    endfunction

    initial begin
        for (int i = 0; i < 3; i++) f_rows[i] = '0;
        set_sum = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // F at reset is zero: every line vanishes
        add_point(0, 0, 0, 0, 0);
        add_point(32767, -32768, -32768, 32767, 1);
        wait_idle();

        // all coefficients at the positive and negative extremes
        write_reg(REG_F_ROW0, {3{COEF_MAX}});
        write_reg(REG_F_ROW1, {3{COEF_MIN}});
        write_reg(REG_F_ROW2, {COEF_MIN, COEF_MAX, COEF_MIN});
        write_reg(REG_UNUSED, {CFG_W{1'b1}});
        add_point(32767, 32767, 32767, 32767, 0);
        add_point(-32768, -32768, -32768, -32768, 0);
        add_point(32767, -32768, 32767, -32768, 0);
        add_point(-32768, 32767, 32767, 32767, 1);
        add_point(16, 32, -48, 0, 1);
        wait_idle();

        // both lines are tiny in x and y against a large residual: saturated results
        write_reg(REG_F_ROW0, {COEF_BITS'(1), {(2*COEF_BITS){1'b0}}});
        write_reg(REG_F_ROW1, '0);
        write_reg(REG_F_ROW2, {COEF_MAX, {COEF_BITS{1'b0}}, COEF_BITS'(1)});
        add_point(100, -200, 300, 400, 0);
        add_point(32767, 32767, -32768, 32767, 0);
        add_point(0, 0, 0, 0, 1);
        wait_idle();

        // a small well-behaved F
        write_reg(REG_F_ROW0, {COEF_BITS'(-5), COEF_BITS'(300), COEF_BITS'(7)});
        write_reg(REG_F_ROW1, {COEF_BITS'(900), COEF_BITS'(-3), COEF_BITS'(-250)});
        write_reg(REG_F_ROW2, {COEF_BITS'(1000), COEF_BITS'(-800), COEF_BITS'(20)});
        add_point(160, 320, 170, 330, 0);
        add_point(-1600, 800, -1590, 790, 0);
        add_point(0, 16, 0, 16, 1);
        wait_idle();

        // random phases: new F each time, one phase with no idling
        for (int ph = 0; ph < 9; ph++) begin
            no_idle = (ph == 4);
            if (ph == 8) begin
                write_reg(REG_F_ROW0, {CFG_W{1'b1}});
                write_reg(REG_F_ROW1, {1'b0, {(CFG_W-1){1'b1}}});
                write_reg(REG_F_ROW2, CFG_W'({$urandom, $urandom}));
            end else begin
                for (int r = 0; r < 3; r++)
                    if (ph % 3 == 0)
                        write_reg(CFG_IDX_W'(r), CFG_W'({$urandom, $urandom}));
                    else
                        write_reg(CFG_IDX_W'(r), {rand_coef(), rand_coef(), rand_coef()});
            end
            if ($urandom_range(0, 1)) write_reg(REG_UNUSED, CFG_W'({$urandom, $urandom}));
            for (int k = 0; k < 80; k++)
                add_point(int'($signed(rand_coord())), int'($signed(rand_coord())),
                          int'($signed(rand_coord())), int'($signed(rand_coord())),
                          $urandom_range(0, 9) == 0);
            wait_idle();
        end

        repeat (150) @(posedge aclk);
        if (mismatches == 0 && expected_scores.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
hdl/see_pkg.sv
hdl/see_ctrl.sv
hdl/see_datapath.sv
hdl/symmetric_epipolar_error.sv
tb/sv/tb_symmetric_epipolar_error.sv
